/* design/mcp_pkg.sv */
// Package for the control message parser: field and type codes, payload types.
// No dependencies; used by every module of the parser.
package mcp_pkg;

	localparam logic [3:0] F_TYPE  = 4'd0;
	localparam logic [3:0] F_CID   = 4'd1;
	localparam logic [3:0] F_SEQ   = 4'd2;
	localparam logic [3:0] F_LINK  = 4'd3;
	localparam logic [3:0] F_PROBE = 4'd4;
	localparam logic [3:0] F_RCID  = 4'd5;
	localparam logic [3:0] F_STAMP = 4'd6;
	localparam logic [3:0] F_REV   = 4'd7;
	localparam logic [3:0] F_FLOW  = 4'd8;
	localparam logic [3:0] F_N     = 4'd9;
	localparam logic [3:0] F_K     = 4'd10;
	localparam logic [3:0] F_L     = 4'd11;
	localparam logic [3:0] F_OWD   = 4'd12;
	localparam logic [3:0] F_QD    = 4'd13;
	localparam logic [3:0] F_SSN   = 4'd14;
	localparam logic [3:0] F_DELAY = 4'd15;

	// parser phase: a field code, or idle
	localparam logic [4:0] PH_IDLE = 5'd16;

	localparam logic [7:0] T_PROBE = 8'd1;
	localparam logic [7:0] T_TSU   = 8'd5;
	localparam logic [7:0] T_ACK   = 8'd6;
	localparam logic [7:0] T_TSA   = 8'd7;

	localparam logic [7:0] HDR_LEN_RESET = 8'd2;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       first;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  msg_type;
		logic [3:0]  field_code;
		logic [31:0] field_value;
		logic [7:0]  element_index;
		logic        last;
		logic        error;
		logic [10:0] total_length;
	} out_item_t;

endpackage

/* design/mcp_front.sv */
// Front end of the parser: byte-serial field assembly and classification.
// Depends on mcp_pkg; emits one field item per completed field into the queue.
module mcp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  mcp_pkg::in_item_t  in_data,
	input  logic [7:0]         hdr_len,
	output logic               push,
	output mcp_pkg::out_item_t push_data
);

	logic [4:0]  phase_q;
	logic [7:0]  type_q;
	logic [1:0]  bif_q;
	logic [31:0] asm_q;
	logic [7:0]  vc_q;
	logic [7:0]  ec_q;

	logic [3:0]  code;
	logic [7:0]  b;
	logic [31:0] asm_nx;
	logic [2:0]  bif_inc;
	logic        done;
	logic        is_vec;
	logic [8:0]  cnt;
	logic        vec_end;
	logic [7:0]  vc_nx;
	logic [4:0]  nxt;
	logic        known;
	logic        run;
	logic        last;
	logic [10:0] total;

	function automatic logic [2:0] field_bytes(input logic [3:0] c);
		case (c)
			mcp_pkg::F_SEQ:   field_bytes = 3'd2;
			mcp_pkg::F_STAMP: field_bytes = 3'd4;
			mcp_pkg::F_SSN:   field_bytes = 3'd3;
			default:          field_bytes = 3'd1;
		endcase
	endfunction

	function automatic logic [9:0] body_bytes(input logic [7:0] t, input logic [7:0] vc);
		case (t)
			mcp_pkg::T_PROBE: body_bytes = 10'd9;
			mcp_pkg::T_TSU:   body_bytes = 10'd7 + {1'b0, vc, 1'b0} + {2'b0, vc};
			mcp_pkg::T_ACK:   body_bytes = 10'd6;
			default:          body_bytes = 10'd12 + {2'b0, vc};
		endcase
	endfunction

	function automatic logic [4:0] next_after(input logic [3:0] c, input logic [7:0] t,
			input logic [7:0] vc);
		logic tsu;
		logic tsa;
		tsu = (t == mcp_pkg::T_TSU);
		tsa = (t == mcp_pkg::T_TSA);
		case (c)
			mcp_pkg::F_CID:   next_after = {1'b0, mcp_pkg::F_SEQ};
			mcp_pkg::F_SEQ:   next_after = (tsu || t == mcp_pkg::T_PROBE) ?
				{1'b0, mcp_pkg::F_LINK} : {1'b0, mcp_pkg::F_STAMP};
			mcp_pkg::F_LINK:  next_after = tsu ? {1'b0, mcp_pkg::F_REV} : {1'b0, mcp_pkg::F_PROBE};
			mcp_pkg::F_PROBE: next_after = {1'b0, mcp_pkg::F_RCID};
			mcp_pkg::F_RCID:  next_after = {1'b0, mcp_pkg::F_STAMP};
			mcp_pkg::F_STAMP: next_after = tsa ? {1'b0, mcp_pkg::F_FLOW} : mcp_pkg::PH_IDLE;
			mcp_pkg::F_REV:   next_after = {1'b0, mcp_pkg::F_FLOW};
			mcp_pkg::F_FLOW:  next_after = tsa ? {1'b0, mcp_pkg::F_SSN} : {1'b0, mcp_pkg::F_N};
			mcp_pkg::F_SSN:   next_after = {1'b0, mcp_pkg::F_DELAY};
			mcp_pkg::F_DELAY: next_after = {1'b0, mcp_pkg::F_N};
			mcp_pkg::F_N: begin
				if (vc == 8'd0)
					next_after = tsu ? {1'b0, mcp_pkg::F_L} : mcp_pkg::PH_IDLE;
				else
					next_after = tsu ? {1'b0, mcp_pkg::F_K} : {1'b0, mcp_pkg::F_OWD};
			end
			mcp_pkg::F_L:     next_after = (vc == 8'd0) ? mcp_pkg::PH_IDLE : {1'b0, mcp_pkg::F_OWD};
			default:          next_after = mcp_pkg::PH_IDLE;
		endcase
	endfunction

	always_comb begin
		b       = in_data.byte_value;
		code    = phase_q[3:0];
		run     = accept && !in_data.first && !phase_q[4];
		known   = (b == mcp_pkg::T_PROBE) || (b == mcp_pkg::T_TSU) ||
			(b == mcp_pkg::T_ACK) || (b == mcp_pkg::T_TSA);
		// start number is big-endian, everything else little-endian
		if (code == mcp_pkg::F_SSN)
			asm_nx = {8'h00, asm_q[15:0], b};
		else
			asm_nx = asm_q | ({24'h0, b} << {bif_q, 3'b000});
		bif_inc = {1'b0, bif_q} + 3'd1;
		done    = (bif_inc >= field_bytes(code));
		is_vec  = (code == mcp_pkg::F_K) || (code == mcp_pkg::F_OWD) || (code == mcp_pkg::F_QD);
		cnt     = {1'b0, ec_q} + 9'd1;
		vec_end = (cnt >= {1'b0, vc_q});
		vc_nx   = (code == mcp_pkg::F_N) ? asm_nx[7:0] : vc_q;
		if (is_vec) begin
			if (!vec_end)
				nxt = phase_q;
			else if (code == mcp_pkg::F_K)
				nxt = {1'b0, mcp_pkg::F_L};
			else if (code == mcp_pkg::F_OWD && type_q == mcp_pkg::T_TSU)
				nxt = {1'b0, mcp_pkg::F_QD};
			else
				nxt = mcp_pkg::PH_IDLE;
		end else begin
			nxt = next_after(code, type_q, vc_nx);
		end
		last  = (nxt == mcp_pkg::PH_IDLE);
		total = {3'b000, hdr_len} + {1'b0, body_bytes(type_q, vc_nx)};

		push      = (accept && in_data.first) || (run && done);
		push_data = '0;
		if (in_data.first) begin
			push_data.msg_type     = b;
			push_data.field_code   = mcp_pkg::F_TYPE;
			push_data.field_value  = {24'h0, b};
			push_data.last         = !known;
			push_data.error        = !known;
			push_data.total_length = known ? 11'd0 : {3'b000, hdr_len};
		end else begin
			push_data.msg_type      = type_q;
			push_data.field_code    = code;
			push_data.field_value   = asm_nx;
			push_data.element_index = is_vec ? ec_q : 8'd0;
			push_data.last          = last;
			push_data.total_length  = last ? total : 11'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mcp_pkg::PH_IDLE;
			type_q  <= '0;
			bif_q   <= '0;
			asm_q   <= '0;
			vc_q    <= '0;
			ec_q    <= '0;
		end else if (accept && in_data.first) begin
			phase_q <= known ? {1'b0, mcp_pkg::F_CID} : mcp_pkg::PH_IDLE;
			type_q  <= b;
			bif_q   <= '0;
			asm_q   <= '0;
			vc_q    <= '0;
			ec_q    <= '0;
		end else if (run) begin
			if (!done) begin
				asm_q <= asm_nx;
				bif_q <= bif_inc[1:0];
			end else begin
				asm_q   <= '0;
				bif_q   <= '0;
				vc_q    <= vc_nx;
				phase_q <= nxt;
				if (is_vec)
					ec_q <= vec_end ? 8'd0 : cnt[7:0];
				else if (code == mcp_pkg::F_N)
					ec_q <= 8'd0;
			end
		end
	end

endmodule

/* design/mcp_back.sv */
// Back end of the parser: field queue and output register.
// Depends on mcp_pkg; fed by mcp_front, drives the result channel.
module mcp_back #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mcp_pkg::out_item_t push_data,
	output logic               full,
	output logic               out_valid,
	input  logic               out_ready,
	output mcp_pkg::out_item_t out_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mcp_pkg::out_item_t mem [DEPTH];

	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	mcp_pkg::out_item_t out_data_q;
	logic          load;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	// move the queue head into the output register when it is free or drained
	assign load      = (cnt_q != '0) && (!out_valid_q || out_ready);
	assign full      = (cnt_q == CW'(DEPTH));
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_data;
		if (load)
			out_data_q <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (load)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			cnt_q <= cnt_q + CW'(push) - CW'(load);
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

/* design/mx_control_message_parser.sv */
// Top level of the control message parser: header length register, front and back.
// Depends on mcp_pkg, mcp_front and mcp_back.
//
//   channel   signals                         direction
//   input     in_valid, in_ready, in_data     bytes in, one transfer per byte
//   output    out_valid, out_ready, out_data  one transfer per completed field
//   config    wr_en, wr_data                  header_len write, no wait
//
// One byte per cycle while in_ready is high; the field assembly state updates in
// the cycle the byte is taken. The queue takes a completed field at the transfer of
// its last byte; out_valid rises when the free or draining output register loads it.
// in_ready drops only when the QUEUE_DEPTH entry field queue is full.
// Reset clears the parser to idle, empties the queue and sets header_len to 2.
module mx_control_message_parser #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mcp_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output mcp_pkg::out_item_t out_data,
	input  logic               wr_en,
	input  logic [7:0]         wr_data
);

	logic [7:0]         hdr_len_q;
	logic               accept;
	logic               push;
	logic               full;
	mcp_pkg::out_item_t push_data;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hdr_len_q <= mcp_pkg::HDR_LEN_RESET;
		else if (wr_en)
			hdr_len_q <= wr_data;
	end

	mcp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_data   (in_data),
		.hdr_len   (hdr_len_q),
		.push      (push),
		.push_data (push_data)
	);

	mcp_back #(
		.DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef NO_ASSERTIONS
	// a start byte always yields the type field
	a_first_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.first |-> push)
		else $error("start byte gave no type field");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_data.error |-> push_data.last)
		else $error("error field not marked last");

	a_len_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		push && !push_data.last |-> push_data.total_length == 11'd0)
		else $error("total length on a non-final field");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("field pushed into a full queue");
`endif

endmodule
